// ----- design/srq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sharded ring queue dispatch - shared package
// Sizes, operation and register codes, payload structs, controller state,
// and the ring fill helper.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int MaxShards        = 8;
  localparam int QueueDepth       = 16;
  localparam int DataW            = 64;
  localparam int MinQueueCapacity = 2;
  localparam int MinShardCount    = 1;

  localparam int ShardIdxW = $clog2(MaxShards);
  localparam int SlotIdxW  = $clog2(QueueDepth);
  localparam int CapW      = $clog2(QueueDepth + 1);
  localparam int ShardCntW = $clog2(MaxShards + 1);
  localparam int SlotAddrW = ShardIdxW + SlotIdxW;
  localparam int SlotCount = MaxShards * QueueDepth;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  // Fixed field widths of the transaction payloads and configuration fields.
  localparam int ShardW    = 8;
  localparam int OccW      = 4;
  localparam int TotalW    = 7;
  localparam int DropW     = 32;
  localparam int CfgShardW = 4;
  localparam int CfgCapW   = 5;

  typedef enum logic {
    KindPush = 1'b0,
    KindPop  = 1'b1
  } op_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgShardCount    = 2'd0,
    CfgQueueCapacity = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    StIdle = 1'b0,
    StExec = 1'b1
  } srq_state_e;

  typedef struct packed {
    logic              kind;
    logic [ShardW-1:0] shard;
    logic [63:0]       event_data;
  } srq_in_t;

  typedef struct packed {
    logic              ok;
    logic [63:0]       out_data;
    logic [OccW-1:0]   shard_occupancy;
    logic [TotalW-1:0] pending_total;
    logic [TotalW-1:0] watermark_total;
    logic [OccW-1:0]   watermark_max;
    logic [DropW-1:0]  dropped_total;
  } srq_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;  // capture input transaction, launch slot read
    logic commit;   // apply operation, load output register
    logic cfg_we;   // configuration write; a known register rebuilds all queues
  } srq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_busy;  // output register holds a result not taken this cycle
  } srq_sts_t;

  // Entries pending in a ring given its write and read index.
  function automatic logic [OccW-1:0] fill_of(input logic [SlotIdxW-1:0] w,
                                              input logic [SlotIdxW-1:0] r,
                                              input logic [CapW-1:0]     cap);
    logic [CapW-1:0] diff;
    if (w >= r) begin
      diff = {1'b0, w} - {1'b0, r};
    end else begin
      diff = cap - {1'b0, r} + {1'b0, w};
    end
    return diff[OccW-1:0];
  endfunction

endpackage

// ----- design/sharded_ring_queue_dispatch_unit.sv -----
// ----------------------------------------------------------------------------
// Sharded ring queue dispatch unit
// One ring queue per shard with high watermarks, running totals and a
// saturating drop counter; push and pop transactions, one result each.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                payload
//   -------  ---------  -----------------------  ---------------------------
//   in       input      in_valid_i / in_ready_o  in_i  (kind, shard, data)
//   out      output     out_valid_o / out_ready_i out_o (ok, data, totals)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each transaction is first accepted: the accept cycle captures it and reads
// the addressed slot from the slot RAM; then the update step updates the ring
// pointers, writes a pushed payload and loads the output register.
// A new transaction is taken while the previous result waits in the output
// register; the update step holds only while that register is full and unread.
// Reset is asynchronous and clears pointers, watermarks and totals at once;
// slot RAM contents are not cleared and need no clearing pass.
// A configuration write to a known register clears all queues and totals.
//
module sharded_ring_queue_dispatch_unit
  import srq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srq_in_t             in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srq_out_t            out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  srq_cmd_t cmd;
  srq_sts_t sts;

  // Sequencer: accept, then apply when the output register frees up.
  srq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Rings, totals, slot RAM and output register.
  srq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_i        (in_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ----- design/srq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module srq_ram #(
  parameter int Width = 64,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/srq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sharded ring queue dispatch - controller
// Two-state sequencer: take a transaction, then apply it once the output
// register can accept the result.
// ----------------------------------------------------------------------------
module srq_ctrl
  import srq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  srq_sts_t sts_i,
  output srq_cmd_t cmd_o
);

  srq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (!sts_i.out_busy) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cfg_ready_o   = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cfg_ready_o   = 1'b1;
        cmd_o.load_in = in_valid_i;
        cmd_o.cfg_we  = cfg_valid_i;
      end
      StExec: begin
        // hold the operation while the previous result is still unread
        cmd_o.commit = !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- design/srq_dp.sv -----
// ----------------------------------------------------------------------------
// Sharded ring queue dispatch - datapath
// Configuration, per-shard ring pointers and watermarks, running totals,
// slot RAM and the output register.
// ----------------------------------------------------------------------------
module srq_dp
  import srq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srq_cmd_t            cmd_i,
  output srq_sts_t            sts_o,
  input  srq_in_t             in_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srq_out_t            out_o
);

  // Effective configuration, clamped when written.
  logic [ShardCntW-1:0] nsh_q;
  logic [CapW-1:0]      cap_q;

  logic [SlotIdxW-1:0] wr_idx_q [MaxShards];
  logic [SlotIdxW-1:0] rd_idx_q [MaxShards];
  logic [OccW-1:0]     peak_q   [MaxShards];
  logic [TotalW-1:0]   pending_q;
  logic [TotalW-1:0]   peak_sum_q;
  logic [OccW-1:0]     peak_max_q;
  logic [DropW-1:0]    drop_q;

  srq_in_t  in_q;
  srq_out_t out_q;
  logic     out_valid_q;

  logic [DataW-1:0] ram_rdata;

  // Clamp incoming configuration values.
  logic [CfgShardW-1:0] cfg_shards;
  logic [CfgCapW-1:0]   cfg_cap;
  logic [ShardCntW-1:0] cfg_nsh;
  logic [CapW-1:0]      cfg_capn;

  assign cfg_shards = cfg_data_i[CfgShardW-1:0];
  assign cfg_cap    = cfg_data_i[CfgCapW-1:0];

  always_comb begin
    priority if (cfg_shards < CfgShardW'(MinShardCount)) begin
      cfg_nsh = ShardCntW'(MinShardCount);
    end else if (cfg_shards > CfgShardW'(MaxShards)) begin
      cfg_nsh = ShardCntW'(MaxShards);
    end else begin
      cfg_nsh = ShardCntW'(cfg_shards);
    end
    priority if (cfg_cap < CfgCapW'(MinQueueCapacity)) begin
      cfg_capn = CapW'(MinQueueCapacity);
    end else if (cfg_cap > CfgCapW'(QueueDepth)) begin
      cfg_capn = CapW'(QueueDepth);
    end else begin
      cfg_capn = CapW'(cfg_cap);
    end
  end

  // Operation decode on the captured transaction.
  logic [ShardIdxW-1:0] s;
  logic                 in_range;
  logic [SlotIdxW-1:0]  w, r, nw, nr, w_new, r_new;
  logic [CapW-1:0]      w_inc, r_inc;
  logic                 full, empty, push_ok, pop_ok, drop;
  logic [OccW-1:0]      occ, cur_peak;

  assign s        = in_q.shard[ShardIdxW-1:0];
  assign in_range = in_q.shard < ShardW'(nsh_q);
  assign w        = wr_idx_q[s];
  assign r        = rd_idx_q[s];
  assign cur_peak = peak_q[s];
  assign w_inc    = {1'b0, w} + CapW'(1);
  assign r_inc    = {1'b0, r} + CapW'(1);
  assign nw       = (w_inc == cap_q) ? '0 : w_inc[SlotIdxW-1:0];
  assign nr       = (r_inc == cap_q) ? '0 : r_inc[SlotIdxW-1:0];
  assign full     = (nw == r);
  assign empty    = (w == r);
  assign push_ok  = in_range && (in_q.kind == KindPush) && !full;
  assign pop_ok   = in_range && (in_q.kind == KindPop) && !empty;
  assign drop     = (in_q.kind == KindPush) && (!in_range || full);
  assign w_new    = push_ok ? nw : w;
  assign r_new    = pop_ok ? nr : r;
  assign occ      = in_range ? fill_of(w_new, r_new, cap_q) : '0;

  // Next values of the running totals.
  logic [TotalW-1:0] pending_d, peak_sum_d;
  logic [OccW-1:0]   peak_max_d, peak_d;
  logic [DropW-1:0]  drop_d;
  logic              raise_peak;

  assign raise_peak = push_ok && (occ > cur_peak);
  assign peak_d     = raise_peak ? occ : cur_peak;
  assign peak_sum_d = raise_peak ? peak_sum_q + TotalW'(occ - cur_peak) : peak_sum_q;
  assign peak_max_d = (raise_peak && (occ > peak_max_q)) ? occ : peak_max_q;
  assign pending_d  = push_ok ? pending_q + TotalW'(1) :
                      pop_ok  ? pending_q - TotalW'(1) : pending_q;
  assign drop_d     = (drop && (drop_q != '1)) ? drop_q + DropW'(1) : drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nsh_q      <= ShardCntW'(MaxShards);
      cap_q      <= CapW'(QueueDepth);
      pending_q  <= '0;
      peak_sum_q <= '0;
      peak_max_q <= '0;
      drop_q     <= '0;
      for (int i = 0; i < MaxShards; i++) begin
        wr_idx_q[i] <= '0;
        rd_idx_q[i] <= '0;
        peak_q[i]   <= '0;
      end
    end else if (cmd_i.cfg_we) begin
      unique case (cfg_index_i)
        CfgShardCount: nsh_q <= cfg_nsh;
        CfgQueueCapacity: cap_q <= cfg_capn;
        default: ;
      endcase
      // a known register rebuilds every queue
      if ((cfg_index_i == CfgShardCount) || (cfg_index_i == CfgQueueCapacity)) begin
        pending_q  <= '0;
        peak_sum_q <= '0;
        peak_max_q <= '0;
        drop_q     <= '0;
        for (int i = 0; i < MaxShards; i++) begin
          wr_idx_q[i] <= '0;
          rd_idx_q[i] <= '0;
          peak_q[i]   <= '0;
        end
      end
    end else if (cmd_i.commit) begin
      wr_idx_q[s] <= w_new;
      rd_idx_q[s] <= r_new;
      peak_q[s]   <= peak_d;
      pending_q   <= pending_d;
      peak_sum_q  <= peak_sum_d;
      peak_max_q  <= peak_max_d;
      drop_q      <= drop_d;
    end
  end

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_i;
    end
  end

  // Slot RAM: read at capture, written at commit.
  logic [ShardIdxW-1:0] rd_s;
  logic [SlotAddrW-1:0] raddr, waddr;

  assign rd_s  = in_i.shard[ShardIdxW-1:0];
  assign raddr = {rd_s, rd_idx_q[rd_s]};
  assign waddr = {s, w};

  srq_ram #(
    .Width (DataW),
    .Depth (SlotCount)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && push_ok),
    .waddr_i (waddr),
    .wdata_i (in_q.event_data[DataW-1:0]),
    .re_i    (cmd_i.load_in),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.ok              <= push_ok || pop_ok;
      out_q.out_data        <= pop_ok ? 64'(ram_rdata) : '0;
      out_q.shard_occupancy <= occ;
      out_q.pending_total   <= pending_d;
      out_q.watermark_total <= peak_sum_d;
      out_q.watermark_max   <= peak_max_d;
      out_q.dropped_total   <= drop_d;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_o          = out_q;

  // A ring never holds more than capacity minus one entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, out_q.shard_occupancy} < cap_q))
    else $error("occupancy reached ring capacity");

  // Pending entries are bounded by the summed watermarks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.pending_total <= out_q.watermark_total))
    else $error("pending total exceeds watermark total");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (TotalW'(out_q.watermark_max) <= out_q.watermark_total))
    else $error("watermark max exceeds watermark total");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.ok) |-> (out_q.out_data == '0))
    else $error("failed operation returned data");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Sharded ring queue dispatch unit - self-checking testbench
// Sends push and pop transactions through the valid/ready input channel with
// random gaps, stalls the result channel at random, predicts every result
// from a private copy of the ring state, and compares them field by field.
// Configuration writes happen only between phases, once the unit is drained.
// ----------------------------------------------------------------------------
module tb_top;
  import srq_pkg::*;

  // Spare register indexes; writes to them must leave the unit untouched.
  localparam logic [CfgIdxW-1:0] CfgSpareIdxA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareIdxB = 2'd3;

  // Generous bound: every item waiting out the longest gap and stall.
  localparam int unsigned CycleLimit = 600000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  srq_in_t             in_i        = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  srq_out_t            out_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  sharded_ring_queue_dispatch_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predicted ring state: configuration, pointers, watermarks and totals.
  // --------------------------------------------------------------------------
  logic [3:0]  shard_setting    = 4'd8;
  logic [4:0]  capacity_setting = 5'd16;

  logic [63:0] ring_slots [MaxShards][QueueDepth];
  int unsigned wr_ptr     [MaxShards] = '{default: 0};
  int unsigned rd_ptr     [MaxShards] = '{default: 0};
  int unsigned ring_peak  [MaxShards] = '{default: 0};
  int unsigned live_total = 0;
  int unsigned peak_total = 0;
  int unsigned peak_top   = 0;
  logic [31:0] drops      = '0;

  srq_in_t     event_q   [$];   // transactions waiting for the driver
  srq_out_t    outcome_q [$];   // predicted results, oldest first
  int unsigned issued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  int unsigned in_gap   = 0;
  int unsigned in_calm  = 0;
  int unsigned out_stall = 0;
  int unsigned out_calm = 0;
  srq_out_t    want;

  // Clamp the shard count register: zero acts as one, above the build limit
  // acts as the build limit.
  function automatic int unsigned active_shards();
    if (shard_setting < MinShardCount) return MinShardCount;
    if (shard_setting > MaxShards) return MaxShards;
    return shard_setting;
  endfunction

  function automatic int unsigned ring_fill(input int unsigned s, input int unsigned cap);
    if (wr_ptr[s] >= rd_ptr[s]) return wr_ptr[s] - rd_ptr[s];
    return cap - (rd_ptr[s] - wr_ptr[s]);
  endfunction

  // Apply one transaction to the predicted rings and return its result.
  function automatic srq_out_t ring_outcome(input srq_in_t item);
    srq_out_t    res;
    int unsigned nsh, cap, s, w, nw, r, f;
    logic        drop_now;
    nsh = active_shards();
    cap = capacity_setting;
    if (cap < MinQueueCapacity) cap = MinQueueCapacity;
    if (cap > QueueDepth) cap = QueueDepth;
    res = '0;
    drop_now = 1'b0;
    if (item.shard < nsh) begin
      s = item.shard;
      if (item.kind == KindPush) begin
        w  = wr_ptr[s] % cap;
        nw = (w + 1) % cap;
        // One slot always stays empty; a push that would fill it is dropped.
        if (nw == rd_ptr[s] % cap) begin
          drop_now = 1'b1;
        end else begin
          ring_slots[s][w] = item.event_data;
          wr_ptr[s] = nw;
          live_total++;
          res.ok = 1'b1;
          f = ring_fill(s, cap);
          if (f > ring_peak[s]) begin
            peak_total += f - ring_peak[s];
            ring_peak[s] = f;
            if (f > peak_top) peak_top = f;
          end
        end
      end else begin
        r = rd_ptr[s] % cap;
        if (r != wr_ptr[s] % cap) begin
          res.out_data = ring_slots[s][r];
          rd_ptr[s] = (r + 1) % cap;
          live_total--;
          res.ok = 1'b1;
        end
      end
      res.shard_occupancy = OccW'(ring_fill(s, cap));
    end else if (item.kind == KindPush) begin
      drop_now = 1'b1;
    end
    // Saturate the drop counter at all ones.
    if (drop_now && drops != '1) drops = drops + 1'b1;
    res.pending_total   = TotalW'(live_total);
    res.watermark_total = TotalW'(peak_total);
    res.watermark_max   = OccW'(peak_top);
    res.dropped_total   = drops;
    return res;
  endfunction

  // Most gaps are short, a few long; now and then a stretch with no gaps.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned p;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    p = $urandom_range(99);
    if (p < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: predict each accepted transaction, then present the next
  // one after its gap. Valid is assigned at most once per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        outcome_q = {outcome_q, ring_outcome(in_i)};
        accepted_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (event_q.size() > 0) begin
          in_i       <= event_q.pop_front();
          in_valid_i <= 1'b1;
          in_gap = pick_gap(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each accepted result against the oldest
  // prediction; stall ready at random.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          $error("result transaction with no prediction waiting");
          mismatch_cnt++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("ok", want.ok, out_o.ok);
          compare_field("out_data", want.out_data, out_o.out_data);
          compare_field("shard_occupancy", want.shard_occupancy, out_o.shard_occupancy);
          compare_field("pending_total", want.pending_total, out_o.pending_total);
          compare_field("watermark_total", want.watermark_total, out_o.watermark_total);
          compare_field("watermark_max", want.watermark_max, out_o.watermark_max);
          compare_field("dropped_total", want.dropped_total, out_o.dropped_total);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_event(input op_kind_e kind, input logic [ShardW-1:0] shard,
                             input logic [63:0] data);
    srq_in_t ev;
    ev.kind       = kind;
    ev.shard      = shard;
    ev.event_data = data;
    event_q = {event_q, ev};
    issued_cnt++;
  endtask

  // Hold until every queued transaction is accepted and every result checked.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (accepted_cnt != issued_cnt || outcome_q.size() != 0);
  endtask

  // Write one register and mirror it in the prediction; a known register
  // rebuilds all rings and totals.
  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgShardCount || idx == CfgQueueCapacity) begin
      if (idx == CfgShardCount) shard_setting = value[3:0];
      else capacity_setting = value[4:0];
      wr_ptr     = '{default: 0};
      rd_ptr     = '{default: 0};
      ring_peak  = '{default: 0};
      live_total = 0;
      peak_total = 0;
      peak_top   = 0;
      drops      = '0;
    end
  endtask

  // Write both registers; randomize the bits above each field.
  task automatic set_geometry(input logic [3:0] shards, input logic [4:0] slots);
    logic [CfgDataW-1:0] v;
    v = CfgDataW'($urandom);
    v[3:0] = shards;
    write_register(CfgShardCount, v);
    v = CfgDataW'($urandom);
    v[4:0] = slots;
    write_register(CfgQueueCapacity, v);
  endtask

  // Bursts aimed at one shard, push-heavy, pop-heavy or mixed, so rings both
  // fill to the drop point and drain to empty; some noise out of range.
  task automatic random_traffic(input int unsigned count);
    int unsigned      nsh, made, burst, focus, push_pct, k, p;
    logic [ShardW-1:0] sh;
    logic [63:0]      data;
    op_kind_e         kind;
    nsh  = active_shards();
    made = 0;
    while (made < count) begin
      burst = $urandom_range(4, 40);
      focus = $urandom_range(nsh - 1);
      case ($urandom_range(2))
        0: begin
          push_pct = 85;
        end
        1: begin
          push_pct = 20;
        end
        default: begin
          push_pct = 55;
        end
      endcase
      for (k = 0; k < burst && made < count; k++) begin
        p = $urandom_range(99);
        if (p < 8) sh = ShardW'($urandom_range(255));
        else if (p < 13) sh = ShardW'(nsh + $urandom_range(2));
        else if (p < 30) sh = ShardW'($urandom_range(nsh - 1));
        else sh = ShardW'(focus);
        kind = ($urandom_range(99) < push_pct) ? KindPush : KindPop;
        p = $urandom_range(19);
        if (p == 0) data = '1;
        else if (p == 1) data = '0;
        else data = {$urandom, $urandom};
        queue_event(kind, sh, data);
        made++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: payload extremes, both operations, empty pop, edge shards,
    // out-of-range push and pop, all under the reset configuration.
    queue_event(KindPush, 8'd0, '1);
    queue_event(KindPush, 8'd0, '0);
    queue_event(KindPop, 8'd0, 64'h0123_4567_89ab_cdef);
    queue_event(KindPop, 8'd0, '0);
    queue_event(KindPop, 8'd0, '0);
    queue_event(KindPush, 8'd7, 64'ha5a5_5a5a_f00f_0ff0);
    queue_event(KindPush, 8'd8, 64'h1111_2222_3333_4444);
    queue_event(KindPush, 8'd255, 64'hdead_beef_cafe_f00d);
    queue_event(KindPop, 8'd255, '1);
    queue_event(KindPop, 8'd7, '0);
    wait_drained();

    // Capacity three holds two entries: third push drops, third pop fails.
    write_register(CfgQueueCapacity, 8'h03);
    queue_event(KindPush, 8'd1, 64'h8000_0000_0000_0001);
    queue_event(KindPush, 8'd1, 64'h7fff_ffff_ffff_fffe);
    queue_event(KindPush, 8'd1, 64'h5555_5555_5555_5555);
    queue_event(KindPop, 8'd1, '0);
    queue_event(KindPop, 8'd1, '0);
    queue_event(KindPop, 8'd1, '0);
    wait_drained();

    set_geometry(4'd8, 5'd16);
    random_traffic(250);
    wait_drained();

    // Spare indexes: rings must keep their contents across these writes.
    write_register(CfgSpareIdxA, CfgDataW'($urandom));
    write_register(CfgSpareIdxB, CfgDataW'($urandom));
    random_traffic(50);
    wait_drained();

    // Zero shards and capacity below the minimum.
    write_register(CfgShardCount, 8'h00);
    write_register(CfgQueueCapacity, 8'h00);
    random_traffic(150);
    wait_drained();

    // Shard count and capacity above the build limits.
    write_register(CfgShardCount, 8'hff);
    write_register(CfgQueueCapacity, 8'hff);
    random_traffic(250);
    wait_drained();

    set_geometry(4'd1, 5'd2);
    random_traffic(100);
    wait_drained();

    set_geometry(4'd3, 5'd5);
    random_traffic(150);
    wait_drained();

    repeat (3) begin
      set_geometry(4'($urandom_range(15)), 5'($urandom_range(31)));
      random_traffic(100);
      wait_drained();
    end

    // Let any stray result surface before the verdict.
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
